/* hw/rtl/gregorian_date_add_days_unit_defines.svh */
// assertion macros used by the date adder datapath
`ifndef GREGORIAN_DATE_ADD_DAYS_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_ADD_DAYS_UNIT_DEFINES_SVH

// same-cycle implication, checked on rising clk outside reset
`define GDAD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on rising clk outside reset
`define GDAD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/gdad_pkg.sv */
// types, constants and calendar functions for the date adder
package gdad_pkg;

	localparam int DayW   = 5;
	localparam int MonthW = 4;
	localparam int YearW  = 12;
	localparam int AddW   = 15;
	localparam int LeftW  = 16;
	localparam int RemW   = 9;

	localparam logic [YearW-1:0]  YEAR_MAX      = 12'd2999;
	localparam logic [YearW-1:0]  LEAP_CYCLE    = 12'd400;
	localparam logic [MonthW-1:0] MONTH_FIRST   = 4'd1;
	localparam logic [MonthW-1:0] MONTH_LAST    = 4'd12;
	localparam logic [MonthW-1:0] MONTH_FEB     = 4'd2;
	localparam logic [DayW-1:0]   FEB_LEAP_DAYS = 5'd29;

	// month lengths in a common year, entry zero unused
	localparam logic [DayW-1:0] MONTH_LEN [13] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// commands from controller to datapath
	typedef struct packed {
		logic load_in;
		logic reduce_step;
		logic check_load;
		logic walk_step;
		logic out_load;
	} gdad_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic reduce_done;
		logic input_bad;
		logic walk_done;
		logic out_free;
	} gdad_sts_t;

	// leap test from the year taken modulo 400
	function automatic logic is_leap(input logic [RemW-1:0] rem);
		logic div4;
		logic century;
		div4    = (rem[1:0] == 2'd0);
		century = (rem == 9'd100) || (rem == 9'd200) || (rem == 9'd300);
		return div4 && !century;
	endfunction

	// month length, zero for a month code that means nothing
	function automatic logic [DayW-1:0] days_in_month(input logic [MonthW-1:0] m,
			input logic leap);
		logic [DayW-1:0] len;
		if (m == MONTH_FEB && leap) begin
			len = FEB_LEAP_DAYS;
		end else if (m <= MONTH_LAST) begin
			len = MONTH_LEN[m];
		end else begin
			len = '0;
		end
		return len;
	endfunction

endpackage

/* hw/rtl/gdad_ctrl.sv */
// controller state machine sequencing the date adder
module gdad_ctrl
	import gdad_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  gdad_sts_t sts,
	output gdad_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_REDUCE = 5'b00010,
		ST_CHECK  = 5'b00100,
		ST_WALK   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (sts.reduce_done) begin
					state_d = ST_CHECK;
				end else begin
					cmd.reduce_step = 1'b1;
				end
			end
			ST_CHECK: begin
				cmd.check_load = 1'b1;
				state_d        = sts.input_bad ? ST_FINISH : ST_WALK;
			end
			ST_WALK: begin
				if (sts.walk_done) begin
					state_d = ST_FINISH;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

/* hw/rtl/gdad_dp.sv */
// datapath: input latch, leap remainder, month walk and result register
module gdad_dp
	import gdad_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [DayW-1:0]   start_day,
	input  logic [MonthW-1:0] start_month,
	input  logic [YearW-1:0]  start_year,
	input  logic [AddW-1:0]   days_to_add,
	input  gdad_cmd_t         cmd,
	output gdad_sts_t         sts,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DayW-1:0]   result_day,
	output logic [MonthW-1:0] result_month,
	output logic [YearW-1:0]  result_year,
	output logic              bad_input
);

	`include "gregorian_date_add_days_unit_defines.svh"

	logic [DayW-1:0]   day_q;
	logic [MonthW-1:0] month_q;
	logic [YearW-1:0]  year_q;
	logic [AddW-1:0]   add_q;
	logic [YearW-1:0]  rem_q;
	logic [LeftW-1:0]  left_q;
	logic              bad_q;
	logic              out_valid_q;
	logic [DayW-1:0]   res_day_q;
	logic [MonthW-1:0] res_month_q;
	logic [YearW-1:0]  res_year_q;
	logic              res_bad_q;

	logic [RemW-1:0]   rem9;
	logic              leap;
	logic [DayW-1:0]   cur_len;
	logic              bad_chk;

	// leap flag and current month length
	assign rem9    = rem_q[RemW-1:0];
	assign leap    = is_leap(rem9);
	assign cur_len = days_in_month(month_q, leap);

	// start date and count checks
	assign bad_chk = (year_q == '0) || (year_q > YEAR_MAX)
		|| (month_q < MONTH_FIRST) || (month_q > MONTH_LAST)
		|| (day_q == '0) || (day_q > cur_len)
		|| (add_q == '0);

	assign sts.reduce_done = (rem_q < LEAP_CYCLE);
	assign sts.input_bad   = bad_chk;
	assign sts.walk_done   = (left_q <= {{(LeftW-DayW){1'b0}}, cur_len});
	assign sts.out_free    = !out_valid_q || !out_stall;

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			day_q   <= start_day;
			month_q <= start_month;
			year_q  <= start_year;
			add_q   <= days_to_add;
			rem_q   <= start_year;
		end else if (cmd.reduce_step) begin
			rem_q <= rem_q - LEAP_CYCLE;
		end else if (cmd.check_load) begin
			bad_q  <= bad_chk;
			left_q <= {{(LeftW-DayW){1'b0}}, day_q} + {{(LeftW-AddW){1'b0}}, add_q};
		end else if (cmd.walk_step) begin
			left_q <= left_q - {{(LeftW-DayW){1'b0}}, cur_len};
			if (month_q == MONTH_LAST) begin
				month_q <= MONTH_FIRST;
				year_q  <= year_q + 12'd1;
				rem_q   <= (rem_q == LEAP_CYCLE - 12'd1) ? '0 : rem_q + 12'd1;
			end else begin
				month_q <= month_q + 4'd1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_bad_q   <= bad_q;
			res_day_q   <= bad_q ? '0 : left_q[DayW-1:0];
			res_month_q <= bad_q ? '0 : month_q;
			res_year_q  <= bad_q ? '0 : year_q;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_day   = res_day_q;
	assign result_month = res_month_q;
	assign result_year  = res_year_q;
	assign bad_input    = res_bad_q;

	// checks
	`GDAD_ASSERT_IMP(a_load_free, cmd.out_load, sts.out_free, "result loaded over a held beat")
	`GDAD_ASSERT_IMP(a_bad_zero, out_valid_q && res_bad_q,
		(res_day_q == '0) && (res_month_q == '0) && (res_year_q == '0), "bad beat not zeroed")
	`GDAD_ASSERT_IMP(a_good_date, out_valid_q && !res_bad_q,
		(res_month_q >= MONTH_FIRST) && (res_month_q <= MONTH_LAST) && (res_day_q != '0),
		"good beat has no valid date")
	`GDAD_ASSERT_NXT(a_walk_rem, cmd.walk_step, rem_q < LEAP_CYCLE, "leap remainder left range")

endmodule

/* hw/rtl/gregorian_date_add_days_unit.sv */
// top level of the gregorian date plus days unit
//
//   channel | signals                                          | handshake
//   --------+--------------------------------------------------+----------------
//   in      | start_day, start_month, start_year, days_to_add  | in_valid/in_stall
//   out     | result_day, result_month, result_year, bad_input | out_valid/out_stall
//
// one beat in, one beat out; a good beat first subtracts 400 from start_year until the
// remainder is below 400 (at most 7 subtract steps), then walks months forward from the
// start month, one per cycle; a bad beat skips the walk (up to 10 subtract steps).
// in_stall is high from acceptance until the result is placed in the output register;
// the output register holds a finished beat while the next one is taken and worked.
// arst_n clears the controller and the output valid; payload registers are not reset.
module gregorian_date_add_days_unit
	import gdad_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [DayW-1:0]   start_day,
	input  logic [MonthW-1:0] start_month,
	input  logic [YearW-1:0]  start_year,
	input  logic [AddW-1:0]   days_to_add,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DayW-1:0]   result_day,
	output logic [MonthW-1:0] result_month,
	output logic [YearW-1:0]  result_year,
	output logic              bad_input
);

	gdad_cmd_t cmd;
	gdad_sts_t sts;

	// sequencer
	gdad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	gdad_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_day    (start_day),
		.start_month  (start_month),
		.start_year   (start_year),
		.days_to_add  (days_to_add),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_day   (result_day),
		.result_month (result_month),
		.result_year  (result_year),
		.bad_input    (bad_input)
	);

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the gregorian date plus days unit
module tb_top
	import gdad_pkg::*;
;

	localparam int unsigned CycleLimit   = 3_000_000;
	localparam int unsigned SettleCycles = 1200;
	localparam int unsigned MaxReports   = 10;

	// one result beat as seen on the output channel
	typedef struct packed {
		logic [DayW-1:0]   day;
		logic [MonthW-1:0] month;
		logic [YearW-1:0]  year;
		logic              bad;
	} date_res_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [DayW-1:0]   start_day;
	logic [MonthW-1:0] start_month;
	logic [YearW-1:0]  start_year;
	logic [AddW-1:0]   days_to_add;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DayW-1:0]   result_day;
	logic [MonthW-1:0] result_month;
	logic [YearW-1:0]  result_year;
	logic              bad_input;

	date_res_t   pending_dates[$];
	bit          sender_gaps_on     = 1'b1;
	bit          receiver_stalls_on = 1'b1;
	bit          hold_results       = 1'b0;
	int unsigned cycle_count        = 0;
	int unsigned mismatch_count     = 0;
	int unsigned beats_sent         = 0;
	int unsigned malformed_sent     = 0;
	int unsigned results_checked    = 0;

	gregorian_date_add_days_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.start_day    (start_day),
		.start_month  (start_month),
		.start_year   (start_year),
		.days_to_add  (days_to_add),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_day   (result_day),
		.result_month (result_month),
		.result_year  (result_year),
		.bad_input    (bad_input)
	);

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("[gregorian_date_add_days_unit] ERROR");
			$finish;
		end
	end

	// length of month m in year y, zero for a month code outside 1..12
	function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
		bit          leap;
		int unsigned len;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		case (m)
			1, 3, 5, 7, 8, 10, 12: len = 31;
			4, 6, 9, 11:           len = 30;
			2:                     len = leap ? 29 : 28;
			default:               len = 0;
		endcase
		return len;
	endfunction

	// expected date after adding n days, or the bad-input beat
	function automatic date_res_t add_days_to_date(input logic [DayW-1:0] d,
			input logic [MonthW-1:0] m, input logic [YearW-1:0] y,
			input logic [AddW-1:0] n);
		date_res_t   res;
		bit          bad;
		int unsigned left;
		int unsigned mm;
		int unsigned yy;
		bad = (y < 1) || (y > 2999) || (m < 1) || (m > 12) || (n == 0);
		if (!bad && (d < 1 || d > month_days(m, y)))
			bad = 1'b1;
		res = '0;
		if (bad) begin
			res.bad = 1'b1;
			return res;
		end
		// day of year plus the count, then walk forward from january
		left = d;
		for (int unsigned i = 1; i < m; i++)
			left += month_days(i, y);
		left += n;
		mm = 1;
		yy = y;
		while (left > month_days(mm, yy)) begin
			left -= month_days(mm, yy);
			mm++;
			if (mm == 13) begin
				mm = 1;
				yy++;
			end
		end
		res.day   = left[DayW-1:0];
		res.month = mm[MonthW-1:0];
		res.year  = yy[YearW-1:0];
		return res;
	endfunction

	// drive one beat and wait for it to be taken
	task automatic send_date(input logic [DayW-1:0] d, input logic [MonthW-1:0] m,
			input logic [YearW-1:0] y, input logic [AddW-1:0] n);
		date_res_t want;
		@(negedge clk);
		while (sender_gaps_on && $urandom_range(99) < 9) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		start_day   = d;
		start_month = m;
		start_year  = y;
		days_to_add = n;
		do @(posedge clk); while (in_stall);
		want = add_days_to_date(d, m, y, n);
		pending_dates.push_back(want);
		beats_sent++;
		if (want.bad)
			malformed_sent++;
	endtask

	// drop valid and wait for every outstanding result
	task automatic finish_pending();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
	endtask

	// count of days: mostly short, some medium, a few up to the maximum
	function automatic logic [AddW-1:0] random_count();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 70)
			return AddW'($urandom_range(1, 400));
		else if (p < 90)
			return AddW'($urandom_range(1, 3000));
		return AddW'($urandom_range(1, 32767));
	endfunction

	// mostly well-formed dates with random content, the rest raw noise
	task automatic send_random_date();
		logic [DayW-1:0]   d;
		logic [MonthW-1:0] m;
		logic [YearW-1:0]  y;
		logic [AddW-1:0]   n;
		int unsigned       p;
		int unsigned       len;
		p = $urandom_range(99);
		if (p < 85) begin
			if ($urandom_range(9) == 0)
				y = YearW'(100 * $urandom_range(1, 29));
			else
				y = YearW'($urandom_range(1, 2999));
			m   = MonthW'($urandom_range(1, 12));
			len = month_days(m, y);
			if ($urandom_range(3) == 0)
				d = DayW'(len);
			else
				d = DayW'($urandom_range(1, len));
			n = random_count();
		end else begin
			d = DayW'($urandom_range(0, 31));
			m = MonthW'($urandom_range(0, 15));
			y = YearW'($urandom_range(0, 4095));
			n = ($urandom_range(2) == 0) ? '0 : AddW'($urandom_range(0, 32767));
		end
		send_date(d, m, y, n);
	endtask

	// receiver stalls
	always @(negedge clk)
		out_stall = hold_results || (receiver_stalls_on && $urandom_range(99) < 9);

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		date_res_t got;
		date_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{result_day, result_month, result_year, bad_input};
			if (pending_dates.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MaxReports)
					$display("unexpected result beat: day %0d month %0d year %0d bad %0b",
						got.day, got.month, got.year, got.bad);
			end else begin
				want = pending_dates.pop_front();
				results_checked++;
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= MaxReports)
						$display("mismatch: want %0d/%0d/%0d bad %0b, got %0d/%0d/%0d bad %0b",
							want.day, want.month, want.year, want.bad,
							got.day, got.month, got.year, got.bad);
				end
			end
		end
	end

	// extremes of range and year-end carries
	task automatic test_extremes();
		send_date(5'd1, 4'd1, 12'd1, 15'd1);
		send_date(5'd31, 4'd12, 12'd2999, 15'd32767);
		send_date(5'd1, 4'd1, 12'd2999, 15'd32767);
		send_date(5'd31, 4'd12, 12'd1999, 15'd1);
		send_date(5'd31, 4'd1, 12'd2024, 15'd29);
		finish_pending();
	endtask

	// leap rules: every fourth year, not centuries, but every fourth century
	task automatic test_leap_years();
		send_date(5'd28, 4'd2, 12'd2000, 15'd1);
		send_date(5'd28, 4'd2, 12'd1900, 15'd1);
		send_date(5'd28, 4'd2, 12'd2100, 15'd1);
		send_date(5'd29, 4'd2, 12'd2000, 15'd365);
		send_date(5'd28, 4'd2, 12'd2004, 15'd2);
		finish_pending();
	endtask

	// every reason for a bad input, plus all ones on every field
	task automatic test_bad_inputs();
		send_date(5'd1, 4'd1, 12'd0, 15'd10);
		send_date(5'd1, 4'd1, 12'd3000, 15'd10);
		send_date(5'd31, 4'd15, 12'd4095, 15'd32767);
		send_date(5'd1, 4'd0, 12'd2000, 15'd10);
		send_date(5'd1, 4'd13, 12'd2000, 15'd10);
		send_date(5'd0, 4'd6, 12'd2000, 15'd10);
		send_date(5'd31, 4'd4, 12'd2000, 15'd10);
		send_date(5'd29, 4'd2, 12'd1900, 15'd10);
		send_date(5'd30, 4'd2, 12'd2000, 15'd10);
		send_date(5'd15, 4'd6, 12'd2000, 15'd0);
		send_date(5'd31, 4'd12, 12'd2999, 15'd0);
		send_date(5'd0, 4'd0, 12'd0, 15'd0);
		finish_pending();
	endtask

	// output register holds a finished beat while the next one is taken
	task automatic test_output_hold();
		@(posedge clk);
		hold_results = 1'b1;
		send_date(5'd10, 4'd3, 12'd1600, 15'd500);
		send_date(5'd31, 4'd8, 12'd2400, 15'd40);
		@(posedge clk);
		hold_results = 1'b0;
		finish_pending();
	endtask

	// random beats with gaps and stalls on both sides
	task automatic test_random_mixed(input int unsigned count);
		repeat (count)
			send_random_date();
		finish_pending();
	endtask

	// long stretch with no gaps and no stalls
	task automatic test_quiet_stretch(input int unsigned count);
		sender_gaps_on     = 1'b0;
		receiver_stalls_on = 1'b0;
		repeat (count)
			send_random_date();
		finish_pending();
		sender_gaps_on     = 1'b1;
		receiver_stalls_on = 1'b1;
	endtask

	// random beats in small groups, sender waits for all results between groups
	task automatic test_paced_random(input int unsigned count);
		int unsigned sent;
		sent = 0;
		while (sent < count) begin
			send_random_date();
			sent++;
			if ($urandom_range(5) == 0)
				finish_pending();
		end
		finish_pending();
	endtask

	// test sequence
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		start_day   = '0;
		start_month = '0;
		start_year  = '0;
		days_to_add = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_leap_years();
		test_bad_inputs();
		test_output_hold();
		test_random_mixed(300);
		test_quiet_stretch(120);
		test_paced_random(120);

		finish_pending();
		repeat (SettleCycles) @(posedge clk);
		mismatch_count += pending_dates.size();

		$display("sent %0d beats (%0d malformed) over directed, hold, random and paced runs",
			beats_sent, malformed_sent);
		$display("checked %0d result beats, %0d failures", results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("[gregorian_date_add_days_unit] OK");
		else
			$display("[gregorian_date_add_days_unit] ERROR");
		$finish;
	end

endmodule
